// ----- src/cgcs_pkg.sv -----
// ----------------------------------------------------------------------------
// cgcs_pkg
// Shared types and constants for the serial CRC generator and checker.
// ----------------------------------------------------------------------------
package cgcs_pkg;

   localparam int POLY_WIDTH   = 32;
   localparam int DEG_WIDTH    = 6;
   localparam int CSR_IDX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH = 32;

   // register indexes on the csr port
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_POLY_LOW_TERMS = 2'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_POLY_DEGREE    = 2'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_CHECK_MODE     = 2'd2;

   typedef struct packed {
      logic data_bit;
      logic end_of_frame;
   } req_type;

   typedef struct packed {
      logic frame_bit;
      logic accepted;
      logic last_result;
   } rsp_type;

   // control broadcast to every cell of the chain
   typedef struct packed {
      logic step;       // a word is taken this cycle
      logic frame_end;  // that word closes the frame
      logic fb_aug;     // feedback of the generator register
      logic top_div;    // top bit of the division register
      logic load_sh;    // capture the new crc into the unload chain
      logic shift_sh;   // move the unload chain up one place
   } cell_ctrl_type;

endpackage

// ----- src/cgcs_cell.sv -----
// ----------------------------------------------------------------------------
// cgcs_cell
// One bit position of the crc chain: generator bit, division bit and unload bit.
// ----------------------------------------------------------------------------
module cgcs_cell
   import cgcs_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cell_ctrl_type ctrl,
   input  logic          active,     // position lies below the degree
   input  logic          poly_bit,
   input  logic          aug_prev,
   input  logic          div_prev,
   input  logic          sh_prev,
   output logic          aug_q,
   output logic          div_q,
   output logic          div_next,
   output logic          sh_q
);

   logic aug_ff, aug_in;
   logic div_ff, div_in;
   logic sh_ff;

   assign aug_in   = active & (aug_prev ^ (ctrl.fb_aug & poly_bit));
   assign div_in   = active & (div_prev ^ (ctrl.top_div & poly_bit));
   assign div_next = div_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         aug_ff <= 1'b0;
         div_ff <= 1'b0;
      end else if (ctrl.step) begin
         aug_ff <= ctrl.frame_end ? 1'b0 : aug_in;
         div_ff <= ctrl.frame_end ? 1'b0 : div_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_sh) begin
         sh_ff <= aug_in;
      end else if (ctrl.shift_sh) begin
         sh_ff <= sh_prev;
      end
   end

   assign aug_q = aug_ff;
   assign div_q = div_ff;
   assign sh_q  = sh_ff;

endmodule

// ----- src/crc_generate_and_check_serial.sv -----
// ----------------------------------------------------------------------------
// crc_generate_and_check_serial
// Bit-serial crc generator and checker with programmable polynomial and degree.
// ----------------------------------------------------------------------------
// channel  dir  handshake              payload
// req      in   req_valid/req_ready    req_data  (data_bit, end_of_frame)
// rsp      out  rsp_valid/rsp_ready    rsp_data  (frame_bit, accepted, last_result)
// csr      in   csr_valid/csr_ready    csr_index, csr_data
//
// one bit per cycle while req_ready is high: each req word steps the cell chain in the cycle it is taken
// generate mode: the frame end word is followed by an unload of degree crc bits,
//   during which req_ready is low; the drain counter sets that length
// reset clears the generator and division bits, the registers (degree 1) and the output stage
// rsp stalls back up into req_ready through the single output register
// ----------------------------------------------------------------------------
module crc_generate_and_check_serial
   import cgcs_pkg::*;
#(
   parameter int MAX_DEGREE = 32
)
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  req_type                   req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output rsp_type                   rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_IDX_WIDTH-1:0]  csr_index,
   input  logic [CSR_DATA_WIDTH-1:0] csr_data
);

   localparam int IDX_W = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
   localparam logic [DEG_WIDTH-1:0] MAX_DEG = DEG_WIDTH'(MAX_DEGREE);

   logic [POLY_WIDTH-1:0] poly_ff;
   logic [DEG_WIDTH-1:0]  degree_ff;
   logic                  check_mode_ff;

   logic [DEG_WIDTH-1:0]  deg_eff;
   logic [IDX_W-1:0]      top_idx;

   logic [MAX_DEGREE-1:0] aug_q, div_q, div_next, sh_q;
   cell_ctrl_type         ctrl;

   logic [DEG_WIDTH-1:0]  drain_cnt_ff, drain_cnt_in;
   rsp_type               rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic draining, load_ok, take;

   // configuration
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         poly_ff       <= '0;
         degree_ff     <= DEG_WIDTH'(1);
         check_mode_ff <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_POLY_LOW_TERMS: poly_ff       <= csr_data;
            CSR_POLY_DEGREE:    degree_ff     <= csr_data[DEG_WIDTH-1:0];
            CSR_CHECK_MODE:     check_mode_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // degree zero acts as one, large values clamp
   always_comb begin
      if (degree_ff == '0) begin
         deg_eff = DEG_WIDTH'(1);
      end else if (degree_ff > MAX_DEG) begin
         deg_eff = MAX_DEG;
      end else begin
         deg_eff = degree_ff;
      end
   end

   assign top_idx = IDX_W'(deg_eff - DEG_WIDTH'(1));

   // handshake
   assign draining  = (drain_cnt_ff != '0);
   assign load_ok   = !rsp_valid_ff || rsp_ready;
   assign req_ready = !draining && load_ok;
   assign take      = req_valid && req_ready;

   assign ctrl.step      = take;
   assign ctrl.frame_end = req_data.end_of_frame;
   assign ctrl.fb_aug    = aug_q[top_idx] ^ req_data.data_bit;
   assign ctrl.top_div   = div_q[top_idx];
   assign ctrl.load_sh   = take && req_data.end_of_frame && !check_mode_ff;
   assign ctrl.shift_sh  = draining && load_ok;

   // cell chain
   for (genvar i = 0; i < MAX_DEGREE; i++) begin : g_cell
      logic poly_bit, aug_prev, div_prev, sh_prev, active;

      assign active = (DEG_WIDTH'(i) < deg_eff);

      if (i < POLY_WIDTH) begin : g_poly
         assign poly_bit = poly_ff[i];
      end else begin : g_nopoly
         assign poly_bit = 1'b0;
      end

      if (i == 0) begin : g_head
         assign aug_prev = 1'b0;
         assign div_prev = req_data.data_bit;
         assign sh_prev  = 1'b0;
      end else begin : g_body
         assign aug_prev = aug_q[i-1];
         assign div_prev = div_q[i-1];
         assign sh_prev  = sh_q[i-1];
      end

      cgcs_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (ctrl),
         .active   (active),
         .poly_bit (poly_bit),
         .aug_prev (aug_prev),
         .div_prev (div_prev),
         .sh_prev  (sh_prev),
         .aug_q    (aug_q[i]),
         .div_q    (div_q[i]),
         .div_next (div_next[i]),
         .sh_q     (sh_q[i])
      );
   end

   // output stage
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      drain_cnt_in = drain_cnt_ff;
      if (draining && load_ok) begin
         rsp_in.frame_bit   = sh_q[top_idx];
         rsp_in.accepted    = 1'b0;
         rsp_in.last_result = (drain_cnt_ff == DEG_WIDTH'(1));
         rsp_valid_in       = 1'b1;
         drain_cnt_in       = drain_cnt_ff - DEG_WIDTH'(1);
      end else if (take) begin
         if (!check_mode_ff) begin
            rsp_in.frame_bit   = req_data.data_bit;
            rsp_in.accepted    = 1'b0;
            rsp_in.last_result = 1'b0;
            rsp_valid_in       = 1'b1;
            if (req_data.end_of_frame) begin
               drain_cnt_in = deg_eff;
            end
         end else if (req_data.end_of_frame) begin
            rsp_in.frame_bit   = 1'b0;
            rsp_in.accepted    = (div_next == '0);
            rsp_in.last_result = 1'b1;
            rsp_valid_in       = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         drain_cnt_ff <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         drain_cnt_ff <= drain_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   // a generated frame end starts an unload of exactly degree crc bits
   a_drain_len: assert property (@(posedge clock) disable iff (reset)
      (take && req_data.end_of_frame && !check_mode_ff) |=> (drain_cnt_ff == $past(deg_eff)))
      else $error("crc unload length differs from degree");

   // the final word of a frame never leaves crc bits behind
   a_last_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.last_result) |-> (drain_cnt_ff == '0))
      else $error("last word marked while crc bits remain");

   // both remainders are clear after a frame end
   a_chain_clear: assert property (@(posedge clock) disable iff (reset)
      (take && req_data.end_of_frame) |=> ((aug_q == '0) && (div_q == '0)))
      else $error("crc chain not cleared after frame end");
`endif

endmodule

// ----- test/crc_generate_and_check_serial_test.sv -----
// ----------------------------------------------------------------------------
// crc_generate_and_check_serial_test
// Self-checking bench for the serial crc generator and checker. A short table
// of directed words and register writes runs first, then random phases over
// many polynomial, degree and mode settings with random idling on both sides.
// Each result word is compared with the crc predictor or a hand-written word.
// ----------------------------------------------------------------------------
module crc_generate_and_check_serial_test;
   import cgcs_pkg::*;

   localparam int MAX_DEG      = 32;
   localparam int QUIET_CYCLES = 40;
   localparam int NUM_DIRECTED = 35;
   localparam int NUM_PHASES   = 8;
   localparam int PHASE_WORDS  = 6;
   localparam int REPORT_LIMIT = 10;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_UNUSED = 2'd3;

   typedef struct packed {
      logic                      is_csr;
      logic [CSR_IDX_WIDTH-1:0]  csr_idx;
      logic [CSR_DATA_WIDTH-1:0] csr_val;
      req_type                   word;
      logic [1:0]                n_typed;
      rsp_type                   t0;
      rsp_type                   t1;
   } dir_row_type;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   req_type                   req_data;
   logic                      rsp_valid;
   logic                      rsp_ready;
   rsp_type                   rsp_data;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [CSR_IDX_WIDTH-1:0]  csr_index;
   logic [CSR_DATA_WIDTH-1:0] csr_data;

   // predictor copy of the registers and the two shift registers
   logic [31:0] cfg_poly   = '0;
   logic [5:0]  cfg_degree = 6'd1;
   logic        cfg_check  = 1'b0;
   logic [31:0] gen_crc    = '0;
   logic [31:0] div_rem    = '0;

   rsp_type     expected_words[$];
   dir_row_type directed_rows[NUM_DIRECTED];
   int          fail_count    = 0;
   int          words_sent    = 0;
   int          send_idle_pct = 0;
   int          rsp_stall_pct = 0;
   int          hold_cycles   = 0;

   crc_generate_and_check_serial #(
      .MAX_DEGREE (MAX_DEG)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("crc_generate_and_check_serial_test: FAIL");
      $finish;
   end

   function automatic int eff_deg();
      int d;
      d = cfg_degree;
      if (d < 1) d = 1;
      if (d > MAX_DEG) d = MAX_DEG;
      return d;
   endfunction

   function automatic logic [31:0] deg_mask(int d);
      return 32'((64'd1 << d) - 64'd1);
   endfunction

   function automatic rsp_type rsp_word(logic fb, logic acc, logic last);
      rsp_type r;
      r.frame_bit   = fb;
      r.accepted    = acc;
      r.last_result = last;
      return r;
   endfunction

   function automatic dir_row_type csr_row(logic [CSR_IDX_WIDTH-1:0] idx,
                                           logic [CSR_DATA_WIDTH-1:0] val);
      dir_row_type r;
      r = '0;
      r.is_csr  = 1'b1;
      r.csr_idx = idx;
      r.csr_val = val;
      return r;
   endfunction

   function automatic dir_row_type word_row(logic b, logic eof, logic [1:0] n,
                                            rsp_type t0, rsp_type t1);
      dir_row_type r;
      r = '0;
      r.word.data_bit     = b;
      r.word.end_of_frame = eof;
      r.n_typed           = n;
      r.t0                = t0;
      r.t1                = t1;
      return r;
   endfunction

   // steps both shift registers and queues the result words of one input word
   function automatic int crc_predict(req_type w);
      int          d;
      int          i;
      int          n;
      logic [31:0] mask;
      logic [31:0] poly;
      logic        top;
      d    = eff_deg();
      mask = deg_mask(d);
      poly = cfg_poly & mask;
      n    = 0;

      top     = gen_crc[d-1];
      gen_crc = (gen_crc << 1) & mask;
      if (top ^ w.data_bit) gen_crc ^= poly;

      top     = div_rem[d-1];
      div_rem = ((div_rem << 1) | 32'(w.data_bit)) & mask;
      if (top) div_rem ^= poly;

      if (!cfg_check) begin
         expected_words.push_back(rsp_word(w.data_bit, 1'b0, 1'b0));
         n = 1;
         if (w.end_of_frame) begin
            for (i = 0; i < d; i++) begin
               expected_words.push_back(rsp_word(gen_crc[d-1-i], 1'b0, i == d - 1));
               n++;
            end
         end
      end else if (w.end_of_frame) begin
         expected_words.push_back(rsp_word(1'b0, div_rem == '0, 1'b1));
         n = 1;
      end

      if (w.end_of_frame) begin
         gen_crc = '0;
         div_rem = '0;
      end
      return n;
   endfunction

   task automatic put_word(req_type w, logic [1:0] n_typed, rsp_type t0, rsp_type t1);
      int n;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = w;
      do @(posedge clock); while (!req_ready);
      words_sent++;
      n = crc_predict(w);
      // rows with hand-written results replace what the predictor queued
      if (n_typed != 0) begin
         repeat (n) void'(expected_words.pop_back());
         expected_words.push_back(t0);
         if (n_typed > 1) expected_words.push_back(t1);
      end
   endtask

   task automatic go_idle();
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_WIDTH-1:0] idx, logic [CSR_DATA_WIDTH-1:0] val);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_POLY_LOW_TERMS: cfg_poly   = val;
         CSR_POLY_DEGREE:    cfg_degree = val[5:0];
         CSR_CHECK_MODE:     cfg_check  = val[0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic send_frame();
      int          d;
      int          len;
      int          i;
      int          flip;
      logic [31:0] mask;
      logic [31:0] poly;
      logic [31:0] acc;
      logic        top;
      logic        b;
      logic        frame_bits[$];
      req_type     w;
      d          = eff_deg();
      mask       = deg_mask(d);
      poly       = cfg_poly & mask;
      frame_bits = {};
      if (!cfg_check) begin
         len = ($urandom_range(9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
         repeat (len) frame_bits.push_back(1'($urandom()));
      end else if ($urandom_range(4) == 0) begin
         // noise frame, often shorter than the degree
         len = $urandom_range(1, d + 6);
         repeat (len) frame_bits.push_back(1'($urandom()));
      end else begin
         // message followed by its own crc, sometimes with one bit flipped
         len = $urandom_range(1, 6);
         acc = '0;
         repeat (len) begin
            b = 1'($urandom());
            frame_bits.push_back(b);
            top = acc[d-1];
            acc = (acc << 1) & mask;
            if (top ^ b) acc ^= poly;
         end
         for (i = d - 1; i >= 0; i--) frame_bits.push_back(acc[i]);
         if ($urandom_range(3) == 0) begin
            flip = $urandom_range(0, frame_bits.size() - 1);
            frame_bits[flip] = ~frame_bits[flip];
         end
      end
      for (i = 0; i < frame_bits.size(); i++) begin
         w.data_bit     = frame_bits[i];
         w.end_of_frame = (i == frame_bits.size() - 1);
         put_word(w, 2'd0, '0, '0);
      end
   endtask

   // receiver: random stalls, plus a long hold-off on request
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_ready = 1'b0;
            hold_cycles--;
         end else begin
            rsp_ready = ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_words.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
               $display("unexpected result word fb=%0b acc=%0b last=%0b",
                        rsp_data.frame_bit, rsp_data.accepted, rsp_data.last_result);
         end else begin
            want = expected_words.pop_front();
            if (rsp_data.frame_bit !== want.frame_bit ||
                rsp_data.accepted !== want.accepted ||
                rsp_data.last_result !== want.last_result) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT)
                  $display({"mismatch: expected fb=%0b acc=%0b last=%0b, ",
                            "got fb=%0b acc=%0b last=%0b"},
                           want.frame_bit, want.accepted, want.last_result,
                           rsp_data.frame_bit, rsp_data.accepted, rsp_data.last_result);
            end
         end
      end
   end

   initial begin
      int          r;
      int          p;
      int          k;
      int          start_words;
      int          deg;
      logic [31:0] val;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_index = CSR_POLY_LOW_TERMS;
      csr_data  = '0;

      directed_rows = '{
         // after reset the polynomial is x, so every crc bit is zero
         word_row(1'b1, 1'b1, 2'd2, rsp_word(1'b1, 1'b0, 1'b0), rsp_word(1'b0, 1'b0, 1'b1)),
         word_row(1'b0, 1'b0, 2'd1, rsp_word(1'b0, 1'b0, 1'b0), '0),
         word_row(1'b0, 1'b1, 2'd2, rsp_word(1'b0, 1'b0, 1'b0), rsp_word(1'b0, 1'b0, 1'b1)),
         // x + 1 gives a parity bit
         csr_row(CSR_POLY_LOW_TERMS, 32'd1),
         word_row(1'b1, 1'b1, 2'd2, rsp_word(1'b1, 1'b0, 1'b0), rsp_word(1'b1, 1'b0, 1'b1)),
         csr_row(CSR_POLY_DEGREE, 32'd32),
         csr_row(CSR_POLY_LOW_TERMS, 32'hFFFF_FFFF),
         word_row(1'b1, 1'b0, 2'd0, '0, '0),
         word_row(1'b0, 1'b0, 2'd0, '0, '0),
         word_row(1'b1, 1'b1, 2'd0, '0, '0),
         csr_row(CSR_CHECK_MODE, 32'd1),
         csr_row(CSR_POLY_DEGREE, 32'd1),
         csr_row(CSR_POLY_LOW_TERMS, 32'd1),
         word_row(1'b1, 1'b0, 2'd0, '0, '0),
         word_row(1'b1, 1'b1, 2'd1, rsp_word(1'b0, 1'b1, 1'b1), '0),
         word_row(1'b1, 1'b1, 2'd1, rsp_word(1'b0, 1'b0, 1'b1), '0),
         // degree zero acts as one
         csr_row(CSR_POLY_DEGREE, 32'd0),
         word_row(1'b0, 1'b1, 2'd1, rsp_word(1'b0, 1'b1, 1'b1), '0),
         // degree 63 acts as 32, frames shorter than the degree
         csr_row(CSR_POLY_DEGREE, 32'd63),
         csr_row(CSR_POLY_LOW_TERMS, 32'h04C1_1DB7),
         word_row(1'b0, 1'b0, 2'd0, '0, '0),
         word_row(1'b1, 1'b1, 2'd0, '0, '0),
         word_row(1'b0, 1'b0, 2'd0, '0, '0),
         word_row(1'b0, 1'b1, 2'd1, rsp_word(1'b0, 1'b1, 1'b1), '0),
         // polynomial change in the middle of a check frame
         word_row(1'b1, 1'b0, 2'd0, '0, '0),
         csr_row(CSR_POLY_LOW_TERMS, 32'h8000_0001),
         word_row(1'b1, 1'b1, 2'd0, '0, '0),
         csr_row(CSR_UNUSED, 32'hA5A5_5A5A),
         // upper data bits are dropped: mode 0, degree 4
         csr_row(CSR_CHECK_MODE, 32'hFFFF_FFFE),
         csr_row(CSR_POLY_DEGREE, 32'hFFFF_FFC4),
         csr_row(CSR_POLY_LOW_TERMS, 32'h0000_0003),
         word_row(1'b1, 1'b0, 2'd0, '0, '0),
         word_row(1'b0, 1'b0, 2'd0, '0, '0),
         // polynomial change in the middle of a generated frame
         csr_row(CSR_POLY_LOW_TERMS, 32'h0000_0009),
         word_row(1'b1, 1'b1, 2'd0, '0, '0)
      };

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (r = 0; r < NUM_DIRECTED; r++) begin
         if (directed_rows[r].is_csr) begin
            go_idle();
            csr_write(directed_rows[r].csr_idx, directed_rows[r].csr_val);
         end else begin
            put_word(directed_rows[r].word, directed_rows[r].n_typed,
                     directed_rows[r].t0, directed_rows[r].t1);
         end
      end

      for (p = 0; p < NUM_PHASES; p++) begin
         go_idle();
         val    = $urandom();
         val[0] = p[0];
         csr_write(CSR_CHECK_MODE, val);
         case ((p / 2) % 6)
            0:       deg = 1;
            1:       deg = 32;
            2:       deg = $urandom_range(2, 8);
            3:       deg = $urandom_range(9, 31);
            4:       deg = 0;
            default: deg = 63;
         endcase
         val      = $urandom();
         val[5:0] = 6'(deg);
         csr_write(CSR_POLY_DEGREE, val);
         if (p % 5 == 1)      val = 32'hFFFF_FFFF;
         else if (p % 5 == 3) val = '0;
         else                 val = $urandom();
         csr_write(CSR_POLY_LOW_TERMS, val);

         case (p % 4)
            0:       begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1:       begin send_idle_pct = 66; rsp_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  rsp_stall_pct = 66; end
            default: begin send_idle_pct = 28; rsp_stall_pct = 28; end
         endcase
         // long output hold-off while the sender keeps offering words
         if (p == 2) hold_cycles = 120;

         start_words = words_sent;
         while (words_sent - start_words < PHASE_WORDS) begin
            send_frame();
            if (p == 5) go_idle();
         end
      end

      @(negedge clock);
      req_valid = 1'b0;
      for (k = 0; k < 20000 && expected_words.size() != 0; k++) @(posedge clock);
      repeat (50) @(posedge clock);
      if (expected_words.size() != 0) begin
         fail_count++;
         $display("%0d expected result words never arrived", expected_words.size());
      end
      if (fail_count == 0) begin
         $display("crc_generate_and_check_serial_test: PASS");
      end else begin
         $display("crc_generate_and_check_serial_test: FAIL");
      end
      $finish;
   end

endmodule
